FILE: sv/packed_dawg_word_lookup_core_defines.svh
// assertion helpers shared by the lookup core
`ifndef PACKED_DAWG_WORD_LOOKUP_CORE_DEFINES_SVH
`define PACKED_DAWG_WORD_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PDWL_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PDWL_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pdwl_pkg.sv
package pdwl_pkg;

    // command codes on the item channel
    localparam logic [1:0] CMD_DICT_WR  = 2'd0;
    localparam logic [1:0] CMD_VOCAB_WR = 2'd1;
    localparam logic [1:0] CMD_CHAR     = 2'd2;

    // configuration register indexes
    localparam logic [0:0] CFG_ROOT_OFFSET = 1'b0;
    localparam logic [0:0] CFG_VOCAB_SIZE  = 1'b1;

    localparam int ADDR_IN_W = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CODE_W = 7;
    localparam int FINAL_BIT = 7;
    localparam int NEXT_BYTES = 4;

    typedef enum logic [1:0] {
        OP_DICT_WR,
        OP_VOCAB_WR,
        OP_CHAR,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        ST_NOT_FOUND = 2'd0,
        ST_FOUND     = 2'd1,
        ST_INVALID   = 2'd2
    } status_t;

    typedef struct packed {
        op_t                  op;
        logic [ADDR_IN_W-1:0] mem_address;
        logic [CODE_W-1:0]    vocab_index;
        logic [7:0]           data_byte;
        logic                 last_char;
    } item_t;

    typedef struct packed {
        logic [ADDR_IN_W-1:0] root_offset;
        logic [7:0]           vocab_size;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } back_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHAR,
        S_HDR,
        S_HDR_D,
        S_EDGE,
        S_LEN,
        S_CODE,
        S_VCMP,
        S_SKIP,
        S_SCAN_END,
        S_TAKE,
        S_TCODE,
        S_TCMP,
        S_NX0,
        S_NX1,
        S_NX2,
        S_NX3,
        S_NHDR,
        S_FINISH
    } back_state_t;

    // code modulo table size by shifted conditional subtraction
    function automatic logic [CODE_W-1:0] vocab_mod(input logic [CODE_W-1:0] v,
                                                     input int unsigned n);
        logic [15:0] r;
        logic [15:0] d;
        r = {9'd0, v};
        for (int s = CODE_W - 1; s >= 0; s--) begin
            d = 16'(n << s);
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[CODE_W-1:0];
    endfunction

endpackage

FILE: sv/pdwl_if.sv
interface pdwl_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [19:0] mem_address;
    logic [6:0]  vocab_index;
    logic [7:0]  data_byte;
    logic        last_char;

    modport source (output valid, command, mem_address, vocab_index, data_byte, last_char,
                    input ready);
    modport sink (input valid, command, mem_address, vocab_index, data_byte, last_char,
                  output ready);
endinterface

interface pdwl_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;

    modport source (output valid, status, input ready);
    modport sink (input valid, status, output ready);
endinterface

interface pdwl_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/pdwl_ram.sv
module pdwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/pdwl_front.sv
module pdwl_front (
    input  logic              clk,
    input  logic              rst_n,
    pdwl_item_if.sink         item,
    output logic              q_valid,
    output pdwl_pkg::item_t   q_item,
    input  logic              q_pop
);

    localparam int QDEPTH = 2;
    localparam int PW = $clog2(QDEPTH);

    pdwl_pkg::item_t slot_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    pdwl_pkg::item_t incoming;
    logic            push;

    // classify the command into an operation
    always_comb
    begin
        incoming.mem_address = item.mem_address;
        incoming.vocab_index = item.vocab_index;
        incoming.data_byte   = item.data_byte;
        incoming.last_char   = item.last_char;
        unique case (item.command)
            pdwl_pkg::CMD_DICT_WR:  incoming.op = pdwl_pkg::OP_DICT_WR;
            pdwl_pkg::CMD_VOCAB_WR: incoming.op = pdwl_pkg::OP_VOCAB_WR;
            pdwl_pkg::CMD_CHAR:     incoming.op = pdwl_pkg::OP_CHAR;
            default:                incoming.op = pdwl_pkg::OP_NOP;
        endcase
    end

    assign item.ready = (count_reg != (PW+1)'(QDEPTH));
    assign push       = item.valid && item.ready;
    assign q_valid    = (count_reg != '0);
    assign q_item     = slot_reg[rd_ptr_reg];

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

FILE: sv/pdwl_back.sv
module pdwl_back #(
    parameter int DICT_BYTES = 1048576,
    parameter int VOCAB_ENTRIES = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pdwl_pkg::cfg_t         cfg,
    input  logic                   q_valid,
    input  pdwl_pkg::item_t        q_item,
    output pdwl_pkg::back_stat_t   stat,
    pdwl_result_if.source          result
);

    localparam int AW = $clog2(DICT_BYTES);
    localparam int VW = $clog2(VOCAB_ENTRIES);
    localparam logic [7:0] VocabLim = 8'(VOCAB_ENTRIES);

    pdwl_pkg::back_state_t state_reg, state_next;
    logic [7:0]   ch_reg, ch_next;
    logic         last_reg, last_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [6:0]   cl_reg, cl_next;
    logic         at_node_reg, at_node_next;
    logic         mis_reg, mis_next;
    logic         err_reg, err_next;
    logic         wf_reg, wf_next;
    logic         in_word_reg, in_word_next;
    logic [AW-1:0] q_reg, q_next;
    logic [6:0]   edges_reg, edges_next;
    logic [6:0]   len_reg, len_next;
    logic [6:0]   k_reg, k_next;
    logic [7:0]   lastb_reg, lastb_next;
    logic [7:0]   code_reg, code_next;
    logic         bad_reg, bad_next;
    logic         hit_reg, hit_next;
    logic [AW-1:0] hitpos_reg, hitpos_next;
    logic [6:0]   hitlen_reg, hitlen_next;
    logic [31:0]  nxt_reg, nxt_next;
    logic         res_valid_reg, res_valid_next;
    pdwl_pkg::status_t res_status_reg, res_status_next;

    logic          dict_we;
    logic [AW-1:0] dict_waddr;
    logic [AW-1:0] dict_raddr;
    logic [7:0]    dict_rdata;
    logic          vocab_we;
    logic [VW-1:0] vocab_waddr;
    logic [VW-1:0] vocab_raddr;
    logic [7:0]    vocab_rdata;
    logic          pop;
    logic          byte_bad;
    logic [6:0]    k_plus;
    logic [31:0]   nxt_full;

    pdwl_ram #(.WIDTH(8), .DEPTH(DICT_BYTES)) u_dict (
        .clk   (clk),
        .we    (dict_we),
        .waddr (dict_waddr),
        .wdata (q_item.data_byte),
        .raddr (dict_raddr),
        .rdata (dict_rdata)
    );

    pdwl_ram #(.WIDTH(8), .DEPTH(VOCAB_ENTRIES)) u_vocab (
        .clk   (clk),
        .we    (vocab_we),
        .waddr (vocab_waddr),
        .wdata (q_item.data_byte),
        .raddr (vocab_raddr),
        .rdata (vocab_rdata)
    );

    assign byte_bad = ({1'b0, dict_rdata[6:0]} >= cfg.vocab_size) ||
                      ({1'b0, dict_rdata[6:0]} >= VocabLim);
    assign k_plus   = k_reg + 7'd1;
    assign nxt_full = {dict_rdata, nxt_reg[23:0]};
    assign pop      = (state_reg == pdwl_pkg::S_IDLE) && q_valid;

    assign dict_we     = pop && (q_item.op == pdwl_pkg::OP_DICT_WR);
    assign dict_waddr  = AW'(q_item.mem_address);
    assign vocab_we    = pop && (q_item.op == pdwl_pkg::OP_VOCAB_WR);
    assign vocab_waddr = VW'(pdwl_pkg::vocab_mod(q_item.vocab_index, VOCAB_ENTRIES));
    assign vocab_raddr = VW'(pdwl_pkg::vocab_mod(dict_rdata[6:0], VOCAB_ENTRIES));

    assign stat.busy     = (state_reg != pdwl_pkg::S_IDLE);
    assign stat.pop      = pop;
    assign result.valid  = res_valid_reg;
    assign result.status = res_status_reg;

    // walk sequencer
    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        last_next       = last_reg;
        wp_next         = wp_reg;
        cl_next         = cl_reg;
        at_node_next    = at_node_reg;
        mis_next        = mis_reg;
        err_next        = err_reg;
        wf_next         = wf_reg;
        in_word_next    = in_word_reg;
        q_next          = q_reg;
        edges_next      = edges_reg;
        len_next        = len_reg;
        k_next          = k_reg;
        lastb_next      = lastb_reg;
        code_next       = code_reg;
        bad_next        = bad_reg;
        hit_next        = hit_reg;
        hitpos_next     = hitpos_reg;
        hitlen_next     = hitlen_reg;
        nxt_next        = nxt_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_status_next = res_status_reg;
        dict_raddr      = wp_reg;

        unique case (state_reg)
            pdwl_pkg::S_IDLE:
            begin
                if (pop && (q_item.op == pdwl_pkg::OP_CHAR))
                begin
                    ch_next   = q_item.data_byte;
                    last_next = q_item.last_char;
                    if (!in_word_reg)
                    begin
                        in_word_next = 1'b1;
                        wp_next      = AW'(cfg.root_offset);
                        at_node_next = 1'b1;
                        cl_next      = '0;
                        wf_next      = 1'b0;
                    end
                    state_next = pdwl_pkg::S_CHAR;
                end
            end
            pdwl_pkg::S_CHAR:
            begin
                if (err_reg || mis_reg)
                begin
                    state_next = pdwl_pkg::S_FINISH;
                end
                else if (at_node_reg)
                begin
                    state_next = pdwl_pkg::S_HDR;
                end
                else
                begin
                    state_next = pdwl_pkg::S_TAKE;
                end
            end
            pdwl_pkg::S_HDR:
            begin
                dict_raddr = wp_reg;
                state_next = pdwl_pkg::S_HDR_D;
            end
            pdwl_pkg::S_HDR_D:
            begin
                edges_next = dict_rdata[6:0];
                q_next     = wp_reg + 1'b1;
                bad_next   = 1'b0;
                hit_next   = 1'b0;
                state_next = (dict_rdata[6:0] == 7'd0) ? pdwl_pkg::S_SCAN_END
                                                      : pdwl_pkg::S_EDGE;
            end
            pdwl_pkg::S_EDGE:
            begin
                dict_raddr = q_reg;
                state_next = pdwl_pkg::S_LEN;
            end
            pdwl_pkg::S_LEN:
            begin
                len_next   = dict_rdata[6:0];
                lastb_next = dict_rdata;
                q_next     = q_reg + 1'b1;
                k_next     = '0;
                dict_raddr = q_reg + 1'b1;
                state_next = (dict_rdata[6:0] == 7'd0) ? pdwl_pkg::S_SKIP
                                                      : pdwl_pkg::S_CODE;
            end
            pdwl_pkg::S_CODE:
            begin
                if (byte_bad)
                begin
                    bad_next = 1'b1;
                end
                lastb_next = dict_rdata;
                if ((k_reg == 7'd0) && !hit_reg)
                begin
                    state_next = pdwl_pkg::S_VCMP;
                end
                else if (k_plus < len_reg)
                begin
                    k_next     = k_plus;
                    dict_raddr = q_reg + AW'(k_plus);
                    state_next = pdwl_pkg::S_CODE;
                end
                else
                begin
                    state_next = pdwl_pkg::S_SKIP;
                end
            end
            pdwl_pkg::S_VCMP:
            begin
                // first code of the edge against the input character
                if (vocab_rdata == ch_reg)
                begin
                    hit_next    = 1'b1;
                    hitpos_next = q_reg;
                    hitlen_next = len_reg;
                end
                if (k_plus < len_reg)
                begin
                    k_next     = k_plus;
                    dict_raddr = q_reg + AW'(k_plus);
                    state_next = pdwl_pkg::S_CODE;
                end
                else
                begin
                    state_next = pdwl_pkg::S_SKIP;
                end
            end
            pdwl_pkg::S_SKIP:
            begin
                q_next = q_reg + AW'(len_reg) +
                         (lastb_reg[pdwl_pkg::FINAL_BIT] ? '0 : AW'(pdwl_pkg::NEXT_BYTES));
                edges_next = edges_reg - 7'd1;
                state_next = (edges_reg == 7'd1) ? pdwl_pkg::S_SCAN_END : pdwl_pkg::S_EDGE;
            end
            pdwl_pkg::S_SCAN_END:
            begin
                if (bad_reg)
                begin
                    err_next   = 1'b1;
                    state_next = pdwl_pkg::S_FINISH;
                end
                else if (!hit_reg)
                begin
                    mis_next   = 1'b1;
                    state_next = pdwl_pkg::S_FINISH;
                end
                else
                begin
                    wp_next      = hitpos_reg;
                    cl_next      = hitlen_reg;
                    at_node_next = 1'b0;
                    state_next   = pdwl_pkg::S_TAKE;
                end
            end
            pdwl_pkg::S_TAKE:
            begin
                if (cl_reg == 7'd0)
                begin
                    mis_next   = 1'b1;
                    state_next = pdwl_pkg::S_FINISH;
                end
                else
                begin
                    dict_raddr = wp_reg;
                    state_next = pdwl_pkg::S_TCODE;
                end
            end
            pdwl_pkg::S_TCODE:
            begin
                code_next  = dict_rdata;
                state_next = pdwl_pkg::S_TCMP;
            end
            pdwl_pkg::S_TCMP:
            begin
                if (vocab_rdata != ch_reg)
                begin
                    mis_next   = 1'b1;
                    state_next = pdwl_pkg::S_FINISH;
                end
                else
                begin
                    wp_next = wp_reg + 1'b1;
                    cl_next = cl_reg - 7'd1;
                    if (cl_reg != 7'd1)
                    begin
                        wf_next    = code_reg[pdwl_pkg::FINAL_BIT];
                        state_next = pdwl_pkg::S_FINISH;
                    end
                    else if (code_reg[pdwl_pkg::FINAL_BIT])
                    begin
                        // edge ends the graph here
                        wf_next = 1'b1;
                        if (!last_reg)
                        begin
                            mis_next = 1'b1;
                        end
                        state_next = pdwl_pkg::S_FINISH;
                    end
                    else
                    begin
                        dict_raddr = wp_reg + 1'b1;
                        state_next = pdwl_pkg::S_NX0;
                    end
                end
            end
            pdwl_pkg::S_NX0:
            begin
                nxt_next[7:0] = dict_rdata;
                dict_raddr    = wp_reg + AW'(1);
                state_next    = pdwl_pkg::S_NX1;
            end
            pdwl_pkg::S_NX1:
            begin
                nxt_next[15:8] = dict_rdata;
                dict_raddr     = wp_reg + AW'(2);
                state_next     = pdwl_pkg::S_NX2;
            end
            pdwl_pkg::S_NX2:
            begin
                nxt_next[23:16] = dict_rdata;
                dict_raddr      = wp_reg + AW'(3);
                state_next      = pdwl_pkg::S_NX3;
            end
            pdwl_pkg::S_NX3:
            begin
                nxt_next = nxt_full;
                if (nxt_full == 32'd0)
                begin
                    wf_next = 1'b1;
                    if (!last_reg)
                    begin
                        mis_next = 1'b1;
                    end
                    state_next = pdwl_pkg::S_FINISH;
                end
                else
                begin
                    dict_raddr = AW'(nxt_full);
                    state_next = pdwl_pkg::S_NHDR;
                end
            end
            pdwl_pkg::S_NHDR:
            begin
                wf_next = dict_rdata[pdwl_pkg::FINAL_BIT];
                if (!last_reg)
                begin
                    wp_next      = AW'(nxt_reg);
                    at_node_next = 1'b1;
                end
                state_next = pdwl_pkg::S_FINISH;
            end
            pdwl_pkg::S_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = pdwl_pkg::S_IDLE;
                end
                else if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        res_status_next = pdwl_pkg::ST_INVALID;
                    end
                    else if (mis_reg || !wf_reg)
                    begin
                        res_status_next = pdwl_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        res_status_next = pdwl_pkg::ST_FOUND;
                    end
                    wp_next      = '0;
                    cl_next      = '0;
                    at_node_next = 1'b1;
                    mis_next     = 1'b0;
                    err_next     = 1'b0;
                    wf_next      = 1'b0;
                    in_word_next = 1'b0;
                    state_next   = pdwl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pdwl_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pdwl_pkg::S_IDLE;
            wp_reg        <= '0;
            cl_reg        <= '0;
            at_node_reg   <= 1'b1;
            mis_reg       <= 1'b0;
            err_reg       <= 1'b0;
            wf_reg        <= 1'b0;
            in_word_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            cl_reg        <= cl_next;
            at_node_reg   <= at_node_next;
            mis_reg       <= mis_next;
            err_reg       <= err_next;
            wf_reg        <= wf_next;
            in_word_reg   <= in_word_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // scan working registers and result payload
    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        last_reg       <= last_next;
        q_reg          <= q_next;
        edges_reg      <= edges_next;
        len_reg        <= len_next;
        k_reg          <= k_next;
        lastb_reg      <= lastb_next;
        code_reg       <= code_next;
        bad_reg        <= bad_next;
        hit_reg        <= hit_next;
        hitpos_reg     <= hitpos_next;
        hitlen_reg     <= hitlen_next;
        nxt_reg        <= nxt_next;
        res_status_reg <= res_status_next;
    end

endmodule

FILE: sv/packed_dawg_word_lookup_core.sv
// Packed DAWG word lookup. Software fills dictionary bytes and vocabulary entries
// through the item channel, sets root_offset and vocab_size on the config port
// while the core is idle, then streams word characters; the character marked last
// returns one status (0 not found, 1 found, 2 invalid vocabulary code). Items go
// through a two-entry queue to a walk sequencer that owns one read port on the
// dictionary RAM, one byte per cycle. Dictionary and vocabulary writes leave the
// queue one per cycle while no walk is in progress. A character inside an edge goes
// through pop, dispatch, code read, vocabulary read, compare and finish. At a node
// a character adds the header and scan end, and per edge the edge, length and skip
// steps and a step per code byte, plus the first-code compare while no edge has
// matched yet; crossing to the next node adds the address and its header. After
// a miss or an invalid code a character goes through pop, dispatch and finish. A
// last character waits in finish while the previous status is still held on the
// result channel. DICT_BYTES is taken as a power of two; addresses wrap within it.
// Both stores power up unwritten and need no clearing pass.
`include "packed_dawg_word_lookup_core_defines.svh"

module packed_dawg_word_lookup_core #(
    parameter int DICT_BYTES = 1048576,
    parameter int VOCAB_ENTRIES = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    pdwl_item_if.sink      item,
    pdwl_result_if.source  result,
    pdwl_cfg_if.sink       cfg
);

    pdwl_pkg::cfg_t       cfg_reg;
    pdwl_pkg::item_t      q_item;
    pdwl_pkg::back_stat_t stat;
    logic                 q_valid;

    // configuration writes, always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pdwl_pkg::CFG_ROOT_OFFSET: cfg_reg.root_offset <= cfg.data[19:0];
                pdwl_pkg::CFG_VOCAB_SIZE:  cfg_reg.vocab_size  <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

    pdwl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (stat.pop)
    );

    pdwl_back #(
        .DICT_BYTES    (DICT_BYTES),
        .VOCAB_ENTRIES (VOCAB_ENTRIES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .stat    (stat),
        .result  (result)
    );

    // checks
    `PDWL_ASSERT_IMP(a_pop_has_item, clk, rst_n, stat.pop, q_valid, "pop from empty queue")
    `PDWL_ASSERT_IMP(a_pop_when_idle, clk, rst_n, stat.pop, !stat.busy, "pop while walking")
    `PDWL_ASSERT_NXT(a_char_starts_walk, clk, rst_n,
                     stat.pop && (q_item.op == pdwl_pkg::OP_CHAR), stat.busy,
                     "character not taken up")
    `PDWL_ASSERT_IMP(a_status_legal, clk, rst_n, result.valid, result.status != 2'd3,
                     "illegal status")

endmodule

FILE: tb/sv/packed_dawg_word_lookup_core_tb.sv
module packed_dawg_word_lookup_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_NODES = 6;
    localparam int MAX_EDGES = 64;
    localparam int PHASE_ITEMS = 185;

    logic clk;
    logic rst_n;

    pdwl_item_if   item_ch ();
    pdwl_result_if res_ch ();
    pdwl_cfg_if    cfg_ch ();

    packed_dawg_word_lookup_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // lookup predictor state
    logic [7:0]  dict_mem [logic [19:0]];
    logic [7:0]  vocab_mem [128];
    logic [19:0] root_reg = '0;
    logic [7:0]  vsize_reg = '0;
    logic [19:0] walk_ptr = '0;
    int unsigned codes_left = 0;
    bit          at_node = 1'b1;
    bit          miss = 1'b0;
    bit          err = 1'b0;
    bit          word_fin = 1'b0;
    bit          in_word = 1'b0;

    pdwl_pkg::status_t status_q [$];
    int          errors = 0;
    int          cycles = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;

    // generated dictionary, offsets relative to its base
    logic [7:0]  img [int];
    int          img_len;
    int          nd_first [MAX_NODES];
    int          nd_cnt [MAX_NODES];
    int          nd_depth [MAX_NODES];
    int          nd_patch [MAX_NODES];
    int          n_nodes;
    int          ed_len [MAX_EDGES];
    int          ed_start [MAX_EDGES];
    int          ed_child [MAX_EDGES];
    int          n_edges;
    logic [7:0]  code_pool [$];

    function automatic logic [7:0] rd(input logic [31:0] a);
        logic [19:0] k;
        k = a[19:0];
        if (dict_mem.exists(k))
        begin
            return dict_mem[k];
        end
        return 8'h00;
    endfunction

    function automatic bit code_bad(input logic [7:0] c);
        int unsigned lim;
        lim = (vsize_reg < 128) ? vsize_reg : 128;
        return c[6:0] >= lim;
    endfunction

    function automatic void word_clear();
        walk_ptr = '0;
        codes_left = 0;
        at_node = 1'b1;
        miss = 1'b0;
        err = 1'b0;
        word_fin = 1'b0;
        in_word = 1'b0;
    endfunction

    // scan all edges of the current node, enter the first match
    function automatic void scan_node(input logic [7:0] ch);
        logic [19:0] q;
        logic [19:0] hit_pos;
        int unsigned edges;
        int unsigned len;
        int unsigned hit_len;
        logic [7:0]  lb;
        logic [7:0]  lastb;
        logic [7:0]  c;
        bit          bad;
        bit          hit;
        bad = 1'b0;
        hit = 1'b0;
        hit_pos = '0;
        hit_len = 0;
        edges = rd(walk_ptr) & 8'h7F;
        q = walk_ptr + 20'd1;
        for (int e = 0; e < edges; e++)
        begin
            lb = rd(q);
            len = lb[6:0];
            lastb = lb;
            q = q + 20'd1;
            for (int k = 0; k < len; k++)
            begin
                if (code_bad(rd(q + k)))
                begin
                    bad = 1'b1;
                end
            end
            c = rd(q);
            if (!hit && len > 0 && vocab_mem[c[6:0]] == ch)
            begin
                hit = 1'b1;
                hit_pos = q;
                hit_len = len;
            end
            if (len > 0)
            begin
                lastb = rd(q + len - 1);
            end
            q = q + 20'(len + (lastb[7] ? 0 : pdwl_pkg::NEXT_BYTES));
        end
        if (bad)
        begin
            err = 1'b1;
        end
        else if (!hit)
        begin
            miss = 1'b1;
        end
        else
        begin
            walk_ptr = hit_pos;
            codes_left = hit_len;
            at_node = 1'b0;
        end
    endfunction

    // consume one word character
    function automatic void take_char(input logic [7:0] ch, input bit last);
        logic [7:0]  code;
        logic [7:0]  hdr;
        logic [19:0] p;
        logic [31:0] nxt;
        if (at_node)
        begin
            scan_node(ch);
            if (err || miss)
            begin
                return;
            end
        end
        if (codes_left == 0)
        begin
            miss = 1'b1;
            return;
        end
        code = rd(walk_ptr);
        if (vocab_mem[code[6:0]] != ch)
        begin
            miss = 1'b1;
            return;
        end
        p = walk_ptr + 20'd1;
        walk_ptr = p;
        codes_left = (codes_left - 1) & 32'h7F;
        if (codes_left != 0)
        begin
            word_fin = code[pdwl_pkg::FINAL_BIT];
            return;
        end
        nxt = '0;
        if (!code[pdwl_pkg::FINAL_BIT])
        begin
            nxt = {rd(p + 3), rd(p + 2), rd(p + 1), rd(p)};
        end
        hdr = rd(nxt);
        word_fin = (nxt == 0) || hdr[pdwl_pkg::FINAL_BIT];
        if (!last)
        begin
            if (nxt == 0)
            begin
                miss = 1'b1;
            end
            else
            begin
                walk_ptr = nxt[19:0];
                at_node = 1'b1;
            end
        end
    endfunction

    // apply one accepted item, returns 1 when a status is due
    function automatic bit lookup_step(input logic [1:0] cmd, input logic [19:0] addr,
                                       input logic [6:0] idx, input logic [7:0] data,
                                       input bit last, output pdwl_pkg::status_t st);
        st = pdwl_pkg::ST_NOT_FOUND;
        if (cmd == pdwl_pkg::CMD_DICT_WR)
        begin
            dict_mem[addr] = data;
            return 1'b0;
        end
        if (cmd == pdwl_pkg::CMD_VOCAB_WR)
        begin
            vocab_mem[idx] = data;
            return 1'b0;
        end
        if (cmd != pdwl_pkg::CMD_CHAR)
        begin
            return 1'b0;
        end
        if (!in_word)
        begin
            in_word = 1'b1;
            walk_ptr = root_reg;
            at_node = 1'b1;
            codes_left = 0;
            word_fin = 1'b0;
        end
        if (!err && !miss)
        begin
            take_char(data, last);
        end
        if (!last)
        begin
            return 1'b0;
        end
        if (err)
        begin
            st = pdwl_pkg::ST_INVALID;
        end
        else if (miss)
        begin
            st = pdwl_pkg::ST_NOT_FOUND;
        end
        else
        begin
            st = word_fin ? pdwl_pkg::ST_FOUND : pdwl_pkg::ST_NOT_FOUND;
        end
        word_clear();
        return 1'b1;
    endfunction

    // send one item and predict it at its transfer
    task automatic send_item(input logic [1:0] cmd, input logic [19:0] addr,
                             input logic [6:0] idx, input logic [7:0] data, input bit last);
        pdwl_pkg::status_t st;
        if (!calm && $urandom_range(0, 99) < 11)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= cmd;
        item_ch.mem_address <= addr;
        item_ch.vocab_index <= idx;
        item_ch.data_byte   <= data;
        item_ch.last_char   <= last;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
        if (lookup_step(cmd, addr, idx, data, last, st))
        begin
            status_q = {status_q, st};
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input bit last);
        send_item(pdwl_pkg::CMD_CHAR, 20'($urandom), 7'($urandom), ch, last);
    endtask

    task automatic dict_wr(input logic [19:0] addr, input logic [7:0] data);
        send_item(pdwl_pkg::CMD_DICT_WR, addr, 7'($urandom), data, 1'($urandom));
    endtask

    task automatic vocab_wr(input logic [6:0] idx, input logic [7:0] data);
        send_item(pdwl_pkg::CMD_VOCAB_WR, 20'($urandom), idx, data, 1'($urandom));
    endtask

    // hold the sender until every status is back and the core has settled
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (status_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [0:0] idx, input logic [19:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == pdwl_pkg::CFG_ROOT_OFFSET)
        begin
            root_reg = data;
        end
        else
        begin
            vsize_reg = data[7:0];
        end
    endtask

    // status checker
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (status_q.size() == 0)
            begin
                $display("%0t: unexpected status transfer, actual %0d", $time, res_ch.status);
                errors++;
            end
            else if (res_ch.status !== status_q[0])
            begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, status_q[0], res_ch.status);
                errors++;
                void'(status_q.pop_front());
            end
            else
            begin
                void'(status_q.pop_front());
            end
        end
    end

    // result backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 11);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // full vocabulary load, extremes at both ends
    task automatic test_vocab_load();
        logic [7:0] ch;
        for (int i = 0; i < 128; i++)
        begin
            if (i == 0)
                ch = 8'h00;
            else if (i == 127)
                ch = 8'hFF;
            else if (i == 5)
                ch = "|";
            else if (i >= 1 && i <= 4)
                ch = 8'("a" + i - 1);
            else if (i % 9 == 0)
                ch = 8'($urandom);
            else
                ch = 8'("a" + $urandom_range(0, 11));
            vocab_wr(7'(i), ch);
        end
    endtask

    // hand-built dictionary: zero-length edge, final code, final next header
    task automatic test_directed_dict();
        logic [7:0] bytes_d [19] = '{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
                                     8'h01, 8'h02, 8'h10, 8'h00, 8'h00, 8'h00, 8'h01,
                                     8'h83, 8'h00, 8'h81, 8'h01, 8'h84};
        for (int i = 0; i < 19; i++)
        begin
            dict_wr(20'(i), bytes_d[i]);
        end
        drain();
        cfg_write(pdwl_pkg::CFG_ROOT_OFFSET, 20'h00000);
        cfg_write(pdwl_pkg::CFG_VOCAB_SIZE, 20'd128);
        // found through next node header
        send_char("a", 1'b0);
        send_char("b", 1'b1);
        // inside an edge, not final
        send_char("a", 1'b1);
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_char("d", 1'b1);
        // final code with no next node
        send_char("c", 1'b1);
        // edge ends without next node while characters remain
        send_char("c", 1'b0);
        send_char("x", 1'b1);
        send_char("x", 1'b1);
        // ignored command
        send_item(2'(pdwl_pkg::OP_NOP), 20'hFFFFF, 7'h7F, 8'hFF, 1'b1);
        // vocabulary change in the middle of a word
        send_char("a", 1'b0);
        vocab_wr(7'd2, "z");
        send_char("z", 1'b1);
        vocab_wr(7'd2, "b");
        send_char("|", 1'b1);
        send_char(8'hFF, 1'b1);
        drain();
    endtask

    // codes at or above the vocabulary size
    task automatic test_invalid_codes();
        cfg_write(pdwl_pkg::CFG_VOCAB_SIZE, 20'd4);
        send_char("a", 1'b0);
        send_char("b", 1'b1);
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_char("d", 1'b1);
        drain();
        cfg_write(pdwl_pkg::CFG_VOCAB_SIZE, 20'd0);
        send_char("c", 1'b1);
        drain();
    endtask

    // build a random packed graph at base, next pointers patched in place
    task automatic build_dict(input logic [19:0] base, input int lim);
        int          cnt;
        int          len;
        int          e;
        int          child;
        logic [7:0]  c;
        logic [7:0]  lastb;
        logic [31:0] ptr;
        img.delete();
        code_pool.delete();
        img_len = 0;
        n_nodes = 1;
        n_edges = 0;
        nd_depth[0] = 0;
        nd_patch[0] = -1;
        for (int n = 0; n < n_nodes; n++)
        begin
            if (nd_patch[n] >= 0)
            begin
                ptr = 32'((base + img_len) & 20'hFFFFF);
                if ($urandom_range(0, 99) < 30)
                    ptr[31:20] = 12'($urandom_range(1, 4095));
                for (int b = 0; b < pdwl_pkg::NEXT_BYTES; b++)
                    img[nd_patch[n] + b] = ptr[8*b +: 8];
            end
            cnt = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 3);
            if (n_edges + cnt > MAX_EDGES)
                cnt = 0;
            nd_first[n] = n_edges;
            nd_cnt[n] = cnt;
            img[img_len++] = 8'(cnt) | ($urandom_range(0, 1) ? 8'h80 : 8'h00);
            for (int k = 0; k < cnt; k++)
            begin
                e = n_edges++;
                len = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 3);
                lastb = 8'(len) | ($urandom_range(0, 1) ? 8'h80 : 8'h00);
                img[img_len++] = lastb;
                ed_len[e] = len;
                ed_start[e] = code_pool.size();
                ed_child[e] = -1;
                for (int j = 0; j < len; j++)
                begin
                    if (lim > 0 && $urandom_range(0, 99) < 92)
                        c = 8'($urandom_range(0, lim - 1));
                    else
                        c = 8'($urandom_range(0, 127));
                    if ($urandom_range(0, 99) < 25)
                        c[pdwl_pkg::FINAL_BIT] = 1'b1;
                    code_pool = {code_pool, c};
                    img[img_len++] = c;
                    lastb = c;
                end
                if (!lastb[pdwl_pkg::FINAL_BIT])
                begin
                    child = -1;
                    if (len > 0 && n_nodes < MAX_NODES && nd_depth[n] < 3 &&
                        $urandom_range(0, 99) < 85)
                    begin
                        child = n_nodes++;
                        nd_depth[child] = nd_depth[n] + 1;
                        nd_patch[child] = img_len;
                    end
                    ed_child[e] = child;
                    for (int b = 0; b < pdwl_pkg::NEXT_BYTES; b++)
                        img[img_len++] = 8'h00;
                end
            end
        end
        for (int i = 0; i < img_len; i++)
        begin
            dict_wr(20'((base + i) & 20'hFFFFF), img[i]);
        end
    endtask

    // one word along a random path, sometimes cut short or corrupted
    task automatic send_path_word();
        logic [7:0] word [$];
        logic [7:0] c;
        int         n;
        int         e;
        bit         stop;
        n = 0;
        stop = 1'b0;
        while (!stop && nd_cnt[n] > 0 && word.size() < 10)
        begin
            e = nd_first[n] + $urandom_range(0, nd_cnt[n] - 1);
            for (int k = 0; k < ed_len[e] && !stop; k++)
            begin
                c = code_pool[ed_start[e] + k];
                word = {word, vocab_mem[c[6:0]]};
                if ($urandom_range(0, 99) < 12)
                    stop = 1'b1;
            end
            if (ed_child[e] < 0 || $urandom_range(0, 99) < 25)
                stop = 1'b1;
            else
                n = ed_child[e];
        end
        if (word.size() == 0)
            word = {word, 8'($urandom)};
        if ($urandom_range(0, 99) < 10)
            word[$urandom_range(0, word.size() - 1)] = 8'($urandom);
        if ($urandom_range(0, 99) < 5)
            word = {word, 8'("a" + $urandom_range(0, 11))};
        for (int i = 0; i < word.size(); i++)
        begin
            send_char(word[i], i == word.size() - 1);
        end
    endtask

    // stray commands between words
    task automatic send_noise(input logic [19:0] base);
        logic [19:0] a;
        int          off;
        case ($urandom_range(0, 2))
            0: send_item(2'(pdwl_pkg::OP_NOP), 20'($urandom), 7'($urandom), 8'($urandom),
                         1'($urandom));
            1: vocab_wr(7'($urandom), ($urandom_range(0, 1)) ? 8'($urandom)
                                                            : 8'("a" + $urandom_range(0, 11)));
            default:
            begin
                a = 20'($urandom);
                off = int'((a - base) & 20'hFFFFF);
                // keep the live graph intact
                dict_wr(a, (off < img_len) ? img[off] : 8'($urandom));
            end
        endcase
    endtask

    task automatic run_dict_phase(input logic [19:0] base, input logic [7:0] vsz,
                                  input bit no_idle, input int n_items);
        int lim;
        int start;
        lim = (vsz < 128) ? vsz : 128;
        calm = no_idle;
        start = items_sent;
        build_dict(base, lim);
        drain();
        cfg_write(pdwl_pkg::CFG_ROOT_OFFSET, base);
        cfg_write(pdwl_pkg::CFG_VOCAB_SIZE, 20'(vsz));
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                send_noise(base);
            end
            else
            begin
                send_path_word();
            end
        end
        drain();
        calm = 1'b0;
    endtask

    task automatic test_random_dicts();
        run_dict_phase(20'hFFFFF, 8'd128, 1'b0, PHASE_ITEMS);
        run_dict_phase(20'hFFFF8, 8'd200, 1'b1, PHASE_ITEMS);
        run_dict_phase(20'($urandom), 8'($urandom_range(1, 127)), 1'b0, PHASE_ITEMS);
        run_dict_phase(20'h00000, 8'd255, 1'b0, PHASE_ITEMS);
        run_dict_phase(20'($urandom), 8'($urandom_range(100, 128)), 1'b0, PHASE_ITEMS);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.command     = pdwl_pkg::CMD_DICT_WR;
        item_ch.mem_address = '0;
        item_ch.vocab_index = '0;
        item_ch.data_byte   = '0;
        item_ch.last_char   = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = pdwl_pkg::CFG_ROOT_OFFSET;
        cfg_ch.data         = '0;
        res_ch.ready        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_vocab_load();
        test_directed_dict();
        test_invalid_codes();
        test_random_dicts();
        drain();
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
